### sv/bmms_pkg.sv
package bmms_pkg;

  localparam int TickW   = 14;
  localparam int PeriodW = 16;
  localparam int DelayW  = 22;
  localparam int DbW     = 15;
  localparam int EnW     = 4;
  localparam int CurW    = 16;
  localparam int CfgW    = 22;
  localparam int IdxW    = 3;

  localparam logic [PeriodW-1:0] CntMax  = {PeriodW{1'b1}};
  localparam logic [DelayW-1:0]  StbyMax = {DelayW{1'b1}};

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_ALERT = 1'b1;

  localparam logic [IdxW-1:0] REG_TICK_MS     = 3'd0;
  localparam logic [IdxW-1:0] REG_CELL_PERIOD = 3'd1;
  localparam logic [IdxW-1:0] REG_PACK_PERIOD = 3'd2;
  localparam logic [IdxW-1:0] REG_TEMP_PERIOD = 3'd3;
  localparam logic [IdxW-1:0] REG_SLEEP_DELAY = 3'd4;
  localparam logic [IdxW-1:0] REG_DEADBAND    = 3'd5;
  localparam logic [IdxW-1:0] REG_ENABLES     = 3'd6;

  localparam int EN_CELL = 0;
  localparam int EN_PACK = 1;
  localparam int EN_TEMP = 2;
  localparam int EN_CUR  = 3;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_STANDBY   = 3'd1,
    MODE_CHARGE    = 3'd2,
    MODE_DISCHARGE = 3'd3,
    MODE_SLEEP     = 3'd4
  } mode_t;

  typedef struct packed {
    logic [TickW-1:0]   tick_ms;
    logic [PeriodW-1:0] cell_period;
    logic [PeriodW-1:0] pack_period;
    logic [PeriodW-1:0] temp_period;
    logic [DelayW-1:0]  sleep_delay;
    logic [DbW-1:0]     deadband;
    logic [EnW-1:0]     enables;
  } cfg_t;

  typedef struct packed {
    logic  strobe_cell_voltage;
    logic  strobe_pack_voltage;
    logic  strobe_temperature;
    logic  strobe_current;
    mode_t mode;
    logic  mode_changed;
  } result_t;

endpackage

### sv/bmms_cfg.sv
module bmms_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bmms_pkg::IdxW-1:0]    cfg_index,
  input  logic [bmms_pkg::CfgW-1:0]    cfg_data,
  output bmms_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms     <= bmms_pkg::TickW'(250);
      cfg.cell_period <= bmms_pkg::PeriodW'(250);
      cfg.pack_period <= bmms_pkg::PeriodW'(250);
      cfg.temp_period <= bmms_pkg::PeriodW'(2000);
      cfg.sleep_delay <= bmms_pkg::DelayW'(600000);
      cfg.deadband    <= bmms_pkg::DbW'(20);
      cfg.enables     <= {bmms_pkg::EnW{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmms_pkg::REG_TICK_MS:     cfg.tick_ms     <= cfg_data[bmms_pkg::TickW-1:0];
        bmms_pkg::REG_CELL_PERIOD: cfg.cell_period <= cfg_data[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_PACK_PERIOD: cfg.pack_period <= cfg_data[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_TEMP_PERIOD: cfg.temp_period <= cfg_data[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_SLEEP_DELAY: cfg.sleep_delay <= cfg_data[bmms_pkg::DelayW-1:0];
        bmms_pkg::REG_DEADBAND:    cfg.deadband    <= cfg_data[bmms_pkg::DbW-1:0];
        bmms_pkg::REG_ENABLES:     cfg.enables     <= cfg_data[bmms_pkg::EnW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/bmms_core.sv
module bmms_core (
  input  logic                         clk,
  input  logic                         rst,
  input  bmms_pkg::cfg_t               cfg,
  input  logic                         advance,
  input  logic                         op,
  input  logic signed [bmms_pkg::CurW-1:0] current_ma,
  input  logic                         balancing_idle,
  output bmms_pkg::result_t            result
);

  logic [bmms_pkg::PeriodW-1:0] cell_elapsed, cell_elapsed_next;
  logic [bmms_pkg::PeriodW-1:0] pack_elapsed, pack_elapsed_next;
  logic [bmms_pkg::PeriodW-1:0] temp_elapsed, temp_elapsed_next;
  logic                         alert_pending, alert_pending_next;
  bmms_pkg::mode_t              mode_reg, mode_next;
  logic [bmms_pkg::DelayW-1:0]  standby_elapsed, standby_elapsed_next;

  logic                         s_cell, s_pack, s_temp, s_cur;
  logic signed [bmms_pkg::CurW:0] cur_x, db_pos, db_neg;
  logic                         at_charge, at_discharge;
  logic [bmms_pkg::DelayW:0]    stby_sum;

  function automatic logic [bmms_pkg::PeriodW:0] step_counter(
    input logic [bmms_pkg::PeriodW-1:0] cnt,
    input logic [bmms_pkg::TickW-1:0]   tick,
    input logic [bmms_pkg::PeriodW-1:0] period,
    input logic                         en
  );
    logic [bmms_pkg::PeriodW:0]   sum;
    logic [bmms_pkg::PeriodW-1:0] v;
    sum = {1'b0, cnt} + (bmms_pkg::PeriodW+1)'(tick);
    v   = sum[bmms_pkg::PeriodW] ? bmms_pkg::CntMax : sum[bmms_pkg::PeriodW-1:0];
    // result is {strobe, new count}
    if (!en) begin
      step_counter = '0;
    end else if (v >= period) begin
      step_counter = {1'b1, {bmms_pkg::PeriodW{1'b0}}};
    end else begin
      step_counter = {1'b0, v};
    end
  endfunction

  always_comb begin
    {s_cell, cell_elapsed_next} = step_counter(cell_elapsed, cfg.tick_ms, cfg.cell_period,
                                               cfg.enables[bmms_pkg::EN_CELL]);
    {s_pack, pack_elapsed_next} = step_counter(pack_elapsed, cfg.tick_ms, cfg.pack_period,
                                               cfg.enables[bmms_pkg::EN_PACK]);
    {s_temp, temp_elapsed_next} = step_counter(temp_elapsed, cfg.tick_ms, cfg.temp_period,
                                               cfg.enables[bmms_pkg::EN_TEMP]);

    s_cur              = alert_pending && cfg.enables[bmms_pkg::EN_CUR];
    alert_pending_next = alert_pending && !s_cur;

    cur_x        = {current_ma[bmms_pkg::CurW-1], current_ma};
    db_pos       = {2'b00, cfg.deadband};
    db_neg       = -db_pos;
    at_charge    = cur_x >= db_pos;
    at_discharge = cur_x <= db_neg;
    stby_sum     = {1'b0, standby_elapsed} + (bmms_pkg::DelayW+1)'(cfg.tick_ms);

    mode_next            = mode_reg;
    standby_elapsed_next = standby_elapsed;
    priority if (mode_reg == bmms_pkg::MODE_SLEEP) begin
      if (at_charge || at_discharge) mode_next = bmms_pkg::MODE_STANDBY;
    end else if (!at_charge && !at_discharge) begin
      mode_next = bmms_pkg::MODE_STANDBY;
      if (standby_elapsed >= cfg.sleep_delay) begin
        if (balancing_idle) begin
          standby_elapsed_next = '0;
          mode_next            = bmms_pkg::MODE_SLEEP;
        end
      end else begin
        standby_elapsed_next = stby_sum[bmms_pkg::DelayW] ? bmms_pkg::StbyMax
                                                          : stby_sum[bmms_pkg::DelayW-1:0];
      end
    end else if (at_charge) begin
      standby_elapsed_next = '0;
      mode_next            = bmms_pkg::MODE_CHARGE;
    end else begin
      standby_elapsed_next = '0;
      mode_next            = bmms_pkg::MODE_DISCHARGE;
    end

    result.strobe_cell_voltage = s_cell;
    result.strobe_pack_voltage = s_pack;
    result.strobe_temperature  = s_temp;
    result.strobe_current      = s_cur;
    result.mode                = mode_next;
    result.mode_changed        = mode_next != mode_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_elapsed    <= '0;
      pack_elapsed    <= '0;
      temp_elapsed    <= '0;
      alert_pending   <= 1'b0;
      mode_reg        <= bmms_pkg::MODE_NONE;
      standby_elapsed <= '0;
    end else if (advance) begin
      if (op == bmms_pkg::OP_ALERT) begin
        alert_pending <= 1'b1;
      end else begin
        cell_elapsed    <= cell_elapsed_next;
        pack_elapsed    <= pack_elapsed_next;
        temp_elapsed    <= temp_elapsed_next;
        alert_pending   <= alert_pending_next;
        mode_reg        <= mode_next;
        standby_elapsed <= standby_elapsed_next;
      end
    end
  end

endmodule

### sv/battery_monitor_mode_sequencer.sv
// a tick beat's result is valid once it has passed the input register, then the
// result register; alert beats give no result
// throughput: one beat per cycle, limited only by the result register draining
// the input register is freed in the same cycle the result register is taken
// reset: synchronous, active high; clears counters, pending alert, mode to none,
// and loads the configuration registers with their default values
module battery_monitor_mode_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bmms_pkg::IdxW-1:0]         cfg_index,
  input  logic [bmms_pkg::CfgW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic signed [bmms_pkg::CurW-1:0]  current_ma,
  input  logic                              balancing_idle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              strobe_cell_voltage,
  output logic                              strobe_pack_voltage,
  output logic                              strobe_temperature,
  output logic                              strobe_current,
  output logic [2:0]                        mode,
  output logic                              mode_changed
);

  bmms_pkg::cfg_t    cfg;
  bmms_pkg::result_t result;
  bmms_pkg::result_t out_reg;

  logic                             s1_valid;
  logic                             s1_op;
  logic signed [bmms_pkg::CurW-1:0] s1_cur;
  logic                             s1_bal;
  logic                             advance;
  logic                             load_out;

  bmms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // alerts never need the result register, so they drain regardless
  assign advance  = s1_valid && (s1_op == bmms_pkg::OP_ALERT || !out_valid || out_ready);
  assign load_out = advance && s1_op == bmms_pkg::OP_TICK;
  assign in_ready = !s1_valid || advance;

  bmms_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .advance        (advance),
    .op             (s1_op),
    .current_ma     (s1_cur),
    .balancing_idle (s1_bal),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_op  <= op;
      s1_cur <= current_ma;
      s1_bal <= balancing_idle;
    end
    if (load_out) begin
      out_reg <= result;
    end
  end

  assign strobe_cell_voltage = out_reg.strobe_cell_voltage;
  assign strobe_pack_voltage = out_reg.strobe_pack_voltage;
  assign strobe_temperature  = out_reg.strobe_temperature;
  assign strobe_current      = out_reg.strobe_current;
  assign mode                = out_reg.mode;
  assign mode_changed        = out_reg.mode_changed;

`ifndef NO_ASSERTIONS
  // a tick beat stuck behind a full, stalled result register must hold off input
  a_tick_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op == bmms_pkg::OP_TICK && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while tick beat is blocked");

  // after reset both stages are empty and input is open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // an alert beat in the input register never reaches the result register
  a_alert_no_result: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op == bmms_pkg::OP_ALERT && !out_valid |=> !out_valid)
    else $error("alert beat produced a result");
`endif

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class mode_scoreboard;
    bmms_pkg::cfg_t                       cfg;
    logic [bmms_pkg::PeriodW-1:0]         cell_ms;
    logic [bmms_pkg::PeriodW-1:0]         pack_ms;
    logic [bmms_pkg::PeriodW-1:0]         temp_ms;
    logic                                 alert_pending;
    bmms_pkg::mode_t                      mode_q;
    logic [bmms_pkg::DelayW-1:0]          standby_ms;
    bmms_pkg::result_t                    expected_reports[$];
    int                                   errors;

    function void reset();
      cfg.tick_ms     = bmms_pkg::TickW'(250);
      cfg.cell_period = bmms_pkg::PeriodW'(250);
      cfg.pack_period = bmms_pkg::PeriodW'(250);
      cfg.temp_period = bmms_pkg::PeriodW'(2000);
      cfg.sleep_delay = bmms_pkg::DelayW'(600000);
      cfg.deadband    = bmms_pkg::DbW'(20);
      cfg.enables     = 4'hF;
      cell_ms         = '0;
      pack_ms         = '0;
      temp_ms         = '0;
      alert_pending   = 1'b0;
      mode_q          = bmms_pkg::MODE_NONE;
      standby_ms      = '0;
      expected_reports.delete();
      errors          = 0;
    endfunction

    function void set_reg(input logic [bmms_pkg::IdxW-1:0] idx,
                          input logic [bmms_pkg::CfgW-1:0] val);
      case (idx)
        bmms_pkg::REG_TICK_MS:     cfg.tick_ms     = val[bmms_pkg::TickW-1:0];
        bmms_pkg::REG_CELL_PERIOD: cfg.cell_period = val[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_PACK_PERIOD: cfg.pack_period = val[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_TEMP_PERIOD: cfg.temp_period = val[bmms_pkg::PeriodW-1:0];
        bmms_pkg::REG_SLEEP_DELAY: cfg.sleep_delay = val[bmms_pkg::DelayW-1:0];
        bmms_pkg::REG_DEADBAND:    cfg.deadband    = val[bmms_pkg::DbW-1:0];
        bmms_pkg::REG_ENABLES:     cfg.enables     = val[bmms_pkg::EnW-1:0];
        default: ;
      endcase
    endfunction

    // saturating interval counter, cleared on strobe or when disabled
    function logic advance_interval(inout logic [bmms_pkg::PeriodW-1:0] elapsed,
                                    input logic [bmms_pkg::PeriodW-1:0] period,
                                    input logic en);
      int unsigned sum;
      sum = 32'(elapsed) + 32'(cfg.tick_ms);
      if (sum > 32'(bmms_pkg::CntMax)) sum = 32'(bmms_pkg::CntMax);
      if (!en) begin
        elapsed = '0;
        return 1'b0;
      end
      if (sum >= 32'(period)) begin
        elapsed = '0;
        return 1'b1;
      end
      elapsed = sum[bmms_pkg::PeriodW-1:0];
      return 1'b0;
    endfunction

    function void note_beat(input logic o, input logic signed [bmms_pkg::CurW-1:0] cur,
                            input logic bal);
      bmms_pkg::result_t r;
      int                c;
      int                d;
      int unsigned       sum;
      bmms_pkg::mode_t   prior;
      if (o == bmms_pkg::OP_ALERT) begin
        alert_pending = 1'b1;
        return;
      end
      c     = int'(cur);
      d     = int'(cfg.deadband);
      prior = mode_q;
      r.strobe_cell_voltage = advance_interval(cell_ms, cfg.cell_period,
                                               cfg.enables[bmms_pkg::EN_CELL]);
      r.strobe_pack_voltage = advance_interval(pack_ms, cfg.pack_period,
                                               cfg.enables[bmms_pkg::EN_PACK]);
      r.strobe_temperature  = advance_interval(temp_ms, cfg.temp_period,
                                               cfg.enables[bmms_pkg::EN_TEMP]);
      r.strobe_current      = 1'b0;
      if (alert_pending && cfg.enables[bmms_pkg::EN_CUR]) begin
        r.strobe_current = 1'b1;
        alert_pending    = 1'b0;
      end
      if (mode_q == bmms_pkg::MODE_SLEEP) begin
        if (c >= d || c <= -d) mode_q = bmms_pkg::MODE_STANDBY;
      end else if (c < d && c > -d) begin
        mode_q = bmms_pkg::MODE_STANDBY;
        if (standby_ms >= cfg.sleep_delay) begin
          if (bal) begin
            standby_ms = '0;
            mode_q     = bmms_pkg::MODE_SLEEP;
          end
        end else begin
          sum        = 32'(standby_ms) + 32'(cfg.tick_ms);
          standby_ms = (sum > 32'(bmms_pkg::StbyMax)) ? bmms_pkg::StbyMax
                                                       : sum[bmms_pkg::DelayW-1:0];
        end
      end else if (c >= d) begin
        standby_ms = '0;
        mode_q     = bmms_pkg::MODE_CHARGE;
      end else begin
        standby_ms = '0;
        mode_q     = bmms_pkg::MODE_DISCHARGE;
      end
      r.mode         = mode_q;
      r.mode_changed = (mode_q != prior);
      expected_reports.push_back(r);
    endfunction

    function void check_result(input bmms_pkg::result_t got);
      bmms_pkg::result_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.strobe_cell_voltage !== want.strobe_cell_voltage) begin
        $error("strobe_cell_voltage: expected %0d, got %0d",
               want.strobe_cell_voltage, got.strobe_cell_voltage);
        errors++;
      end
      if (got.strobe_pack_voltage !== want.strobe_pack_voltage) begin
        $error("strobe_pack_voltage: expected %0d, got %0d",
               want.strobe_pack_voltage, got.strobe_pack_voltage);
        errors++;
      end
      if (got.strobe_temperature !== want.strobe_temperature) begin
        $error("strobe_temperature: expected %0d, got %0d",
               want.strobe_temperature, got.strobe_temperature);
        errors++;
      end
      if (got.strobe_current !== want.strobe_current) begin
        $error("strobe_current: expected %0d, got %0d",
               want.strobe_current, got.strobe_current);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
      if (got.mode_changed !== want.mode_changed) begin
        $error("mode_changed: expected %0d, got %0d", want.mode_changed, got.mode_changed);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [bmms_pkg::IdxW-1:0]        cfg_index;
  logic [bmms_pkg::CfgW-1:0]        cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic                             op;
  logic signed [bmms_pkg::CurW-1:0] current_ma;
  logic                             balancing_idle;
  logic                             out_valid;
  logic                             out_ready;
  logic                             strobe_cell_voltage;
  logic                             strobe_pack_voltage;
  logic                             strobe_temperature;
  logic                             strobe_current;
  logic [2:0]                       mode;
  logic                             mode_changed;

  mode_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;

  battery_monitor_mode_sequencer dut (.*);

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check every accepted beat, stall at random or on request
  initial begin : result_sink
    int                stall_left;
    bmms_pkg::result_t got;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.strobe_cell_voltage = strobe_cell_voltage;
        got.strobe_pack_voltage = strobe_pack_voltage;
        got.strobe_temperature  = strobe_temperature;
        got.strobe_current      = strobe_current;
        got.mode                = bmms_pkg::mode_t'(mode);
        got.mode_changed        = mode_changed;
        sb.check_result(got);
      end
      if (hold_off_req) begin
        stall_left   = 64;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic bmms_pkg::cfg_t make_cfg(input int tick, input int cell_per,
                                              input int pack, input int temp,
                                              input int sleep_ms, input int db,
                                              input int en);
    bmms_pkg::cfg_t c;
    c.tick_ms     = bmms_pkg::TickW'(tick);
    c.cell_period = bmms_pkg::PeriodW'(cell_per);
    c.pack_period = bmms_pkg::PeriodW'(pack);
    c.temp_period = bmms_pkg::PeriodW'(temp);
    c.sleep_delay = bmms_pkg::DelayW'(sleep_ms);
    c.deadband    = bmms_pkg::DbW'(db);
    c.enables     = bmms_pkg::EnW'(en);
    return c;
  endfunction

  // mostly inside the deadband so standby and sleep get exercised
  function automatic logic signed [bmms_pkg::CurW-1:0] pick_current(input int db,
                                                                   input int out_pct);
    int r;
    int c;
    r = $urandom_range(99);
    if (r < out_pct)
      c = $urandom_range(1) ? db + $urandom_range(200) : -db - $urandom_range(200);
    else if (out_pct > 0 && r < out_pct + 10)
      case ($urandom_range(5))
        0:       c = db;
        1:       c = -db;
        2:       c = db - 1;
        3:       c = 1 - db;
        4:       c = 32767;
        default: c = -32768;
      endcase
    else if (out_pct > 0 && r < out_pct + 18)
      c = $urandom_range(65535) - 32768;
    else
      c = (db == 0) ? 0 : $urandom_range(2 * db - 2) - (db - 1);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c[bmms_pkg::CurW-1:0];
  endfunction

  task automatic write_reg(input logic [bmms_pkg::IdxW-1:0] idx,
                           input logic [bmms_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input bmms_pkg::cfg_t c);
    write_reg(bmms_pkg::REG_TICK_MS, bmms_pkg::CfgW'(c.tick_ms));
    write_reg(bmms_pkg::REG_CELL_PERIOD, bmms_pkg::CfgW'(c.cell_period));
    write_reg(bmms_pkg::REG_PACK_PERIOD, bmms_pkg::CfgW'(c.pack_period));
    write_reg(bmms_pkg::REG_TEMP_PERIOD, bmms_pkg::CfgW'(c.temp_period));
    write_reg(bmms_pkg::REG_SLEEP_DELAY, c.sleep_delay);
    write_reg(bmms_pkg::REG_DEADBAND, bmms_pkg::CfgW'(c.deadband));
    write_reg(bmms_pkg::REG_ENABLES, bmms_pkg::CfgW'(c.enables));
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input logic o, input logic signed [bmms_pkg::CurW-1:0] cur,
                           input logic bal);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= o;
    current_ma     <= cur;
    balancing_idle <= bal;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(o, cur, bal);
  endtask

  // alert beats give no result, so wait for every expected tick result, then leave the input idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input bmms_pkg::cfg_t c, input int beats, input int idle,
                           input int stall, input int alert_pct, input int out_pct,
                           input bit hold);
    int db;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    apply_settings(c);
    db = int'(c.deadband);
    if (hold) hold_off_req = 1'b1;
    repeat (beats) begin
      if ($urandom_range(99) < alert_pct)
        send_beat(bmms_pkg::OP_ALERT, bmms_pkg::CurW'($urandom_range(65535)),
                  1'($urandom_range(1)));
      else
        send_beat(bmms_pkg::OP_TICK, pick_current(db, out_pct), $urandom_range(99) < 80);
    end
    settle();
  endtask

  initial begin
    bmms_pkg::cfg_t c;
    int             k;
    int             t;
    int             db;
    sb = new();
    sb.reset();
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= bmms_pkg::REG_TICK_MS;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    op             <= bmms_pkg::OP_TICK;
    current_ma     <= '0;
    balancing_idle <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold edges, full-scale current, alert service
    send_beat(bmms_pkg::OP_TICK, 16'sd0, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd32767, 1'b0);
    send_beat(bmms_pkg::OP_TICK, -16'sd32768, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd20, 1'b1);
    send_beat(bmms_pkg::OP_TICK, -16'sd20, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd19, 1'b1);
    send_beat(bmms_pkg::OP_TICK, -16'sd19, 1'b0);
    send_beat(bmms_pkg::OP_TICK, 16'sd21, 1'b1);
    send_beat(bmms_pkg::OP_TICK, -16'sd21, 1'b1);
    send_beat(bmms_pkg::OP_ALERT, 16'sd0, 1'b0);
    send_beat(bmms_pkg::OP_ALERT, -16'sd1, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd5, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd100, 1'b1);
    settle();

    // zero delay sleep, zero periods, alert held while current sampling is off
    c = make_cfg(250, 0, 0, 0, 0, 100, 4'b0111);
    apply_settings(c);
    send_beat(bmms_pkg::OP_ALERT, 16'sd0, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd0, 1'b0);
    send_beat(bmms_pkg::OP_TICK, 16'sd0, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd99, 1'b1);
    send_beat(bmms_pkg::OP_TICK, -16'sd100, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd0, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd150, 1'b0);
    settle();
    c.enables = 4'b1000;
    c.tick_ms = '0;
    apply_settings(c);
    send_beat(bmms_pkg::OP_TICK, 16'sd32767, 1'b1);
    send_beat(bmms_pkg::OP_TICK, 16'sd0, 1'b1);
    settle();

    run_phase(make_cfg(250, 250, 500, 2000, 1000, 20, 4'hF), 70, 0, 0, 15, 20, 1'b0);
    run_phase(make_cfg(1, 1, 3, 7, 5, 1, 4'b1010), 70, 48, 0, 15, 25, 1'b0);
    run_phase(make_cfg(16383, 65535, 0, 40000, 0, 300, 4'b0101), 70, 0, 48, 15, 30, 1'b1);
    run_phase(make_cfg(0, 0, 5, 0, 0, 0, 4'h0), 40, 38, 38, 30, 20, 1'b0);
    // long standby run: timer saturates at full scale before sleep
    run_phase(make_cfg(16383, 1000, 65535, 20000, 4194303, 32767, 4'hF),
              330, 38, 38, 8, 0, 1'b0);
    for (k = 0; k < 3; k++) begin
      t  = $urandom_range(1, 10000);
      db = $urandom_range(1) ? $urandom_range(2000) : $urandom_range(32767);
      c  = make_cfg(t, $urandom_range(4 * t), $urandom_range(4 * t), $urandom_range(4 * t),
                    $urandom_range(8 * t), db, (k == 0) ? 4'hF : $urandom_range(15));
      run_phase(c, 60, (k == 1) ? 48 : ((k == 2) ? 38 : 0),
                (k == 0) ? 48 : ((k == 2) ? 38 : 0), 15, 20, 1'b0);
    end

    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (sb.expected_reports.size() != 0) begin
      $error("%0d tick results never arrived", sb.expected_reports.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
